// ----- hdl/timestamped_trace_period_duty_core_macros.svh -----
// ----------------------------------------------------------------------------
// trace period/duty core assertion macros
// shared property wrappers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_TRACE_PERIOD_DUTY_CORE_MACROS_SVH
`define TIMESTAMPED_TRACE_PERIOD_DUTY_CORE_MACROS_SVH

// same-cycle implication
`define TTPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ttpd_pkg.sv -----
// ----------------------------------------------------------------------------
// ttpd_pkg
// types and constants shared by the trace period/duty core
// ----------------------------------------------------------------------------
`default_nettype none

package ttpd_pkg;

  localparam int DATA_W      = 32;
  localparam int ENTRIES_W   = 7;
  localparam int DEPTH_DEF   = 64;
  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int CFG_ADDR_W  = 3;
  localparam int REG_IDX_LSB = 2;

  localparam logic [DATA_W-1:0] EDGE_MASK_RST = DATA_W'(1 << 18);
  localparam logic [DATA_W-1:0] DUTY_SCALE    = DATA_W'(100);

  // input item function codes
  localparam logic FUNC_RECORD  = 1'b0;
  localparam logic FUNC_MEASURE = 1'b1;

  // register indexes
  localparam logic REG_EDGE_MASK   = 1'b0;
  localparam logic REG_CHANGE_ONLY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PER_START,
    ST_PER_WAIT,
    ST_DUTY_START,
    ST_DUTY_WAIT,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/ttpd_if.sv -----
// ----------------------------------------------------------------------------
// ttpd channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface ttpd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [ttpd_pkg::DATA_W-1:0] sample;
  logic [ttpd_pkg::DATA_W-1:0] timestamp;

  modport source (output valid, func, sample, timestamp, input ready);
  modport sink   (input valid, func, sample, timestamp, output ready);
endinterface

interface ttpd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [ttpd_pkg::ENTRIES_W-1:0] entries;
  logic [ttpd_pkg::DATA_W-1:0]    period_cycles;
  logic [ttpd_pkg::DATA_W-1:0]    duty_percent;

  modport source (output valid, accepted, entries, period_cycles, duty_percent, input ready);
  modport sink   (input valid, accepted, entries, period_cycles, duty_percent, output ready);
endinterface

`default_nettype wire

// ----- hdl/ttpd_trace_mem.sv -----
// ----------------------------------------------------------------------------
// ttpd_trace_mem
// sample and timestamp store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ttpd_trace_mem #(
  parameter int DEPTH = ttpd_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [ttpd_pkg::DATA_W-1:0] wr_sample,
  input  wire logic [ttpd_pkg::DATA_W-1:0] wr_time,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [ttpd_pkg::DATA_W-1:0] rd_sample,
  output logic      [ttpd_pkg::DATA_W-1:0] rd_time
);

  logic [ttpd_pkg::DATA_W-1:0] sample_mem [DEPTH];
  logic [ttpd_pkg::DATA_W-1:0] time_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sample_mem[wr_addr] <= wr_sample;
      time_mem[wr_addr]   <= wr_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_sample <= sample_mem[rd_addr];
      rd_time   <= time_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ttpd_divider.sv -----
// ----------------------------------------------------------------------------
// ttpd_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ttpd_divider (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ttpd_pkg::div_req_t req,
  output ttpd_pkg::div_rsp_t      rsp
);

  localparam int W = ttpd_pkg::DATA_W;

  logic [ttpd_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           done_r;
  logic [W-1:0]                   rem_r;
  logic [W-1:0]                   quo_r;
  logic [W-1:0]                   dvsr_r;
  logic [W:0]                     shifted;
  logic [W:0]                     trial;
  logic                           fits;

  // shift in the next dividend bit and try the subtraction
  assign shifted = {rem_r, quo_r[W-1]};
  assign trial   = shifted - {1'b0, dvsr_r};
  assign fits    = shifted >= {1'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == ttpd_pkg::DIV_CNT_W'(1));
      if (req.start) begin
        cnt_r <= ttpd_pkg::DIV_CNT_W'(ttpd_pkg::DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - ttpd_pkg::DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      quo_r  <= req.dividend;
      dvsr_r <= req.divisor;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? trial[W-1:0] : shifted[W-1:0];
      quo_r <= {quo_r[W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ----- hdl/timestamped_trace_period_duty_core.sv -----
// ----------------------------------------------------------------------------
// timestamped_trace_period_duty_core
// trace capture buffer with rising-edge period and duty measurement
// ----------------------------------------------------------------------------
// in_chan takes items: func 0 records sample and timestamp into the trace,
// func 1 measures the average period and duty over the stored trace.
// out_chan gives exactly one result per item from an output register.
// cfg_* is an apb-style port: edge_mask at 0x0, change_only at 0x4.
// record: result is registered at the accepting edge, so one transfer per
// cycle is sustained while out_chan keeps up.
// measure: a trace scan through the memory read port, then two passes of
// the shared divider, period first and duty second, and a final load of
// the result into the output register once that register is free.
// in_chan.ready is low during a measurement and while a result waits in
// the output register and out_chan.ready is low; a stalled receiver holds
// the result and the block simply waits.
// reset clears fill count, registers, sequencer and output valid; the trace
// memory is not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_trace_period_duty_core #(
  parameter int DEPTH = ttpd_pkg::DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  ttpd_in_if.sink                              in_chan,
  ttpd_out_if.source                           out_chan,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [ttpd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [ttpd_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic      [ttpd_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int W  = ttpd_pkg::DATA_W;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // ---------------- configuration registers ----------------
  logic [W-1:0] edge_mask_r;
  logic         change_only_r;
  logic         cfg_wr;
  logic         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[ttpd_pkg::REG_IDX_LSB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_mask_r   <= ttpd_pkg::EDGE_MASK_RST;
      change_only_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ttpd_pkg::REG_EDGE_MASK:   edge_mask_r   <= cfg_pwdata;
        ttpd_pkg::REG_CHANGE_ONLY: change_only_r <= cfg_pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ttpd_pkg::REG_EDGE_MASK:   cfg_prdata = edge_mask_r;
      ttpd_pkg::REG_CHANGE_ONLY: cfg_prdata = {{(W-1){1'b0}}, change_only_r};
    endcase
  end

  // ---------------- sequencer state ----------------
  ttpd_pkg::seq_state_t state_r, state_nxt;

  logic [CW-1:0] fill_r;
  logic [CW-1:0] scan_cnt_r;
  logic [W-1:0]  last_sample_r;   // copy of newest stored sample

  logic          out_valid_r;
  logic          out_accepted_r;
  logic [ttpd_pkg::ENTRIES_W-1:0] out_entries_r;
  logic [W-1:0]  out_period_r;
  logic [W-1:0]  out_duty_r;

  logic          out_free;
  logic          in_ready;
  logic          in_fire;
  logic          out_fire;
  logic          measure_go;
  logic          record_go;
  logic          trace_full;
  logic          skip;
  logic          store;
  logic          rd_en;
  logic          done_load;

  assign out_free   = !out_valid_r || out_chan.ready;
  assign in_ready   = (state_r == ttpd_pkg::ST_IDLE) && out_free;
  assign in_fire    = in_chan.valid && in_ready;
  assign out_fire   = out_valid_r && out_chan.ready;
  assign measure_go = in_fire && (in_chan.func == ttpd_pkg::FUNC_MEASURE);
  assign record_go  = in_fire && (in_chan.func == ttpd_pkg::FUNC_RECORD);

  assign trace_full = (fill_r == CW'(DEPTH));
  // change-only skip; the very first sample is always stored
  assign skip  = change_only_r && (fill_r != '0) && (last_sample_r == in_chan.sample);
  assign store = record_go && !trace_full && !skip;

  // ---------------- measurement accumulators ----------------
  logic          rd_vld_r;
  logic          rd_first_r;
  logic          prev_high_r;
  logic          seen_rise_r;
  logic          in_high_r;
  logic [W-1:0]  last_rise_r;
  logic [W-1:0]  per_sum_r;
  logic [W-1:0]  high_sum_r;
  logic [CW-1:0] count_r;
  logic [W-1:0]  period_r;

  logic [W-1:0]  rd_sample;
  logic [W-1:0]  rd_time;
  logic          curr_high;
  logic          rise;
  logic          fall;
  logic [W-1:0]  diff;

  ttpd_pkg::div_req_t div_req;
  ttpd_pkg::div_rsp_t div_rsp;

  ttpd_trace_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (store),
    .wr_addr   (fill_r[AW-1:0]),
    .wr_sample (in_chan.sample),
    .wr_time   (in_chan.timestamp),
    .rd_en     (rd_en),
    .rd_addr   (scan_cnt_r[AW-1:0]),
    .rd_sample (rd_sample),
    .rd_time   (rd_time)
  );

  ttpd_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // edge detection on the entry coming out of the memory
  assign curr_high = |(rd_sample & edge_mask_r);
  assign rise      = !prev_high_r && curr_high;
  assign fall      = prev_high_r && !curr_high;
  // timer counts down, so earlier minus later is the elapsed time
  assign diff      = last_rise_r - rd_time;

  // ---------------- next state and unit control ----------------
  always_comb begin
    state_nxt        = state_r;
    rd_en            = 1'b0;
    done_load        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = per_sum_r;
    div_req.divisor  = W'(count_r);
    unique case (state_r)
      ttpd_pkg::ST_IDLE: begin
        if (measure_go) begin
          state_nxt = ttpd_pkg::ST_SCAN;
        end
      end
      ttpd_pkg::ST_SCAN: begin
        // issue one read per cycle, leave once the last one is consumed
        if (scan_cnt_r != fill_r) begin
          rd_en = 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = ttpd_pkg::ST_PER_START;
        end
      end
      ttpd_pkg::ST_PER_START: begin
        div_req.start = 1'b1;
        state_nxt     = ttpd_pkg::ST_PER_WAIT;
      end
      ttpd_pkg::ST_PER_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ttpd_pkg::ST_DUTY_START;
        end
      end
      ttpd_pkg::ST_DUTY_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = high_sum_r * ttpd_pkg::DUTY_SCALE;
        div_req.divisor  = per_sum_r;
        state_nxt        = ttpd_pkg::ST_DUTY_WAIT;
      end
      ttpd_pkg::ST_DUTY_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ttpd_pkg::ST_DONE;
        end
      end
      ttpd_pkg::ST_DONE: begin
        if (out_free) begin
          done_load = 1'b1;
          state_nxt = ttpd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ttpd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttpd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- trace fill ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (store) begin
      fill_r <= fill_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      last_sample_r <= in_chan.sample;
    end
  end

  // ---------------- scan and accumulate ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
      rd_first_r <= 1'b0;
    end else begin
      rd_vld_r   <= rd_en;
      rd_first_r <= (scan_cnt_r == '0);
      if (measure_go) begin
        scan_cnt_r <= '0;
      end else if (rd_en) begin
        scan_cnt_r <= scan_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (measure_go) begin
      seen_rise_r <= 1'b0;
      in_high_r   <= 1'b0;
      last_rise_r <= '0;
      per_sum_r   <= '0;
      high_sum_r  <= '0;
      count_r     <= '0;
    end else if (rd_vld_r) begin
      prev_high_r <= curr_high;
      // the first entry only seeds the previous level
      if (!rd_first_r) begin
        if (rise) begin
          if (seen_rise_r) begin
            per_sum_r <= per_sum_r + diff;
            count_r   <= count_r + CW'(1);
          end
          last_rise_r <= rd_time;
          seen_rise_r <= 1'b1;
          in_high_r   <= 1'b1;
        end else if (fall && in_high_r) begin
          high_sum_r <= high_sum_r + diff;
          in_high_r  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ttpd_pkg::ST_PER_WAIT) && div_rsp.done) begin
      period_r <= (count_r == '0) ? '0 : div_rsp.quotient;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (record_go || done_load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (record_go) begin
      out_accepted_r <= !trace_full;
      out_entries_r  <= ttpd_pkg::ENTRIES_W'(store ? fill_r + CW'(1) : fill_r);
      out_period_r   <= '0;
      out_duty_r     <= '0;
    end else if (done_load) begin
      out_accepted_r <= 1'b1;
      out_entries_r  <= ttpd_pkg::ENTRIES_W'(fill_r);
      out_period_r   <= period_r;
      out_duty_r     <= ((count_r == '0) || (per_sum_r == '0)) ? '0 : div_rsp.quotient;
    end
  end

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.accepted      = out_accepted_r;
  assign out_chan.entries       = out_entries_r;
  assign out_chan.period_cycles = out_period_r;
  assign out_chan.duty_percent  = out_duty_r;

  // ---------------- assertions ----------------
`include "timestamped_trace_period_duty_core_macros.svh"

  `TTPD_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= CW'(DEPTH), "trace fill beyond depth")
  `TTPD_ASSERT_IMP(a_busy_not_ready, state_r != ttpd_pkg::ST_IDLE, !in_chan.ready, "ready while busy")
  `TTPD_ASSERT_NXT(a_measure_scan, measure_go, state_r == ttpd_pkg::ST_SCAN, "measure did not start scan")
  `TTPD_ASSERT_NXT(a_full_refused, record_go && trace_full, $stable(fill_r) && !out_accepted_r, "full trace took a record")

endmodule

`default_nettype wire

// ----- tb/tb_timestamped_trace_period_duty_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamped_trace_period_duty_core
// self-checking bench for the trace capture core: a scoreboard class keeps
// its own copy of the trace and registers, predicts every result item and
// checks the result channel field by field; plain tasks drive the input channel
// and the register port, an always block drives out_chan.ready; random idling on both sides
// ----------------------------------------------------------------------------

module tb_timestamped_trace_period_duty_core;

  // one expected result transfer
  typedef struct {
    logic                           accepted;
    logic [ttpd_pkg::ENTRIES_W-1:0] entries;
    logic [ttpd_pkg::DATA_W-1:0]    period_cycles;
    logic [ttpd_pkg::DATA_W-1:0]    duty_percent;
  } trace_result_t;

  // trace predictor plus the queue of results still owed by the core
  class trace_scoreboard;
    logic [ttpd_pkg::DATA_W-1:0] sample_mem [ttpd_pkg::DEPTH_DEF];
    logic [ttpd_pkg::DATA_W-1:0] stamp_mem  [ttpd_pkg::DEPTH_DEF];
    int unsigned                 fill;
    logic [ttpd_pkg::DATA_W-1:0] mask;
    logic                        chg_only;
    trace_result_t               owed_q [$];
    int unsigned                 err_count;

    function new();
      fill      = 0;
      mask      = ttpd_pkg::EDGE_MASK_RST;
      chg_only  = 1'b0;
      err_count = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void set_reg(logic idx, logic [ttpd_pkg::DATA_W-1:0] value);
      if (idx == ttpd_pkg::REG_EDGE_MASK) mask = value;
      else chg_only = value[0];
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      err_count++;
    endtask

    // walk the stored trace for edges of the masked bits
    function void measure_trace(output logic [ttpd_pkg::DATA_W-1:0] period,
                                output logic [ttpd_pkg::DATA_W-1:0] duty);
      logic [ttpd_pkg::DATA_W-1:0] last_rise;
      logic [ttpd_pkg::DATA_W-1:0] high_sum;
      logic [ttpd_pkg::DATA_W-1:0] per_sum;
      logic [ttpd_pkg::DATA_W-1:0] count;
      bit                          seen_rise;
      bit                          in_high;
      bit                          prev_hi;
      bit                          curr_hi;
      last_rise = '0;
      high_sum  = '0;
      per_sum   = '0;
      count     = '0;
      seen_rise = 0;
      in_high   = 0;
      for (int i = 1; i < fill; i++) begin
        prev_hi = (sample_mem[i-1] & mask) != '0;
        curr_hi = (sample_mem[i] & mask) != '0;
        if (!prev_hi && curr_hi) begin
          if (seen_rise) begin
            per_sum = per_sum + (last_rise - stamp_mem[i]);
            count   = count + 1;
          end
          last_rise = stamp_mem[i];
          seen_rise = 1;
          in_high   = 1;
        end else if (prev_hi && !curr_hi && in_high) begin
          high_sum = high_sum + (last_rise - stamp_mem[i]);
          in_high  = 0;
        end
      end
      period = (count == '0) ? '0 : per_sum / count;
      duty   = (count == '0 || per_sum == '0) ? '0 :
               (ttpd_pkg::DUTY_SCALE * high_sum) / per_sum;
    endfunction

    function void note_item(logic func, logic [ttpd_pkg::DATA_W-1:0] smp,
                            logic [ttpd_pkg::DATA_W-1:0] stamp);
      trace_result_t r;
      r.accepted      = 1'b1;
      r.period_cycles = '0;
      r.duty_percent  = '0;
      if (func == ttpd_pkg::FUNC_MEASURE) begin
        measure_trace(r.period_cycles, r.duty_percent);
      end else if (fill >= ttpd_pkg::DEPTH_DEF) begin
        r.accepted = 1'b0;
      end else if (!(chg_only && fill != 0 && sample_mem[fill-1] == smp)) begin
        sample_mem[fill] = smp;
        stamp_mem[fill]  = stamp;
        fill++;
      end
      r.entries = ttpd_pkg::ENTRIES_W'(fill);
      owed_q.push_back(r);
    endfunction

    task check_result(logic acc, logic [ttpd_pkg::ENTRIES_W-1:0] ent,
                      logic [ttpd_pkg::DATA_W-1:0] per,
                      logic [ttpd_pkg::DATA_W-1:0] duty);
      trace_result_t r;
      if (owed_q.size() == 0) begin
        report("result transfer with no item outstanding");
      end else begin
        r = owed_q.pop_front();
        if (acc !== r.accepted)
          report($sformatf("accepted %b, want %b", acc, r.accepted));
        if (ent !== r.entries)
          report($sformatf("entries %0d, want %0d", ent, r.entries));
        if (per !== r.period_cycles)
          report($sformatf("period_cycles %h, want %h", per, r.period_cycles));
        if (duty !== r.duty_percent)
          report($sformatf("duty_percent %h, want %h", duty, r.duty_percent));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  ttpd_in_if  in_chan ();
  ttpd_out_if out_chan ();

  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [ttpd_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [ttpd_pkg::DATA_W-1:0]     cfg_pwdata;
  logic [ttpd_pkg::DATA_W-1:0]     cfg_prdata;
  logic                            cfg_pready;

  trace_scoreboard sb;

  // set during the stretch where neither side idles
  bit no_idle;

  // running down-counter for generated timestamps, last sample sent
  logic [ttpd_pkg::DATA_W-1:0] stamp_run;
  logic [ttpd_pkg::DATA_W-1:0] last_sample;
  int unsigned                 items_sent;

  timestamped_trace_period_duty_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // receiver: random back-pressure, none during the no-idle stretch
  always @(posedge clk) begin
    out_chan.ready <= no_idle || ($urandom_range(99) >= 37);
  end

  // monitor: values read here are the ones from before this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note_item(in_chan.func, in_chan.sample, in_chan.timestamp);
      if (out_chan.valid && out_chan.ready)
        sb.check_result(out_chan.accepted, out_chan.entries,
                        out_chan.period_cycles, out_chan.duty_percent);
    end
  end

  // one input transfer; valid stays high afterwards so back-to-back items
  // need no second assignment in the same step
  task automatic send_item(logic func, logic [ttpd_pkg::DATA_W-1:0] smp,
                           logic [ttpd_pkg::DATA_W-1:0] stamp);
    while (!no_idle && $urandom_range(99) < 37) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.func      <= func;
    in_chan.sample    <= smp;
    in_chan.timestamp <= stamp;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    if (func == ttpd_pkg::FUNC_RECORD) last_sample = smp;
  endtask

  task automatic record(logic [ttpd_pkg::DATA_W-1:0] smp,
                        logic [ttpd_pkg::DATA_W-1:0] stamp);
    send_item(ttpd_pkg::FUNC_RECORD, smp, stamp);
  endtask

  task automatic measure();
    send_item(ttpd_pkg::FUNC_MEASURE, $urandom(), $urandom());
  endtask

  // register write, only once every owed result has come back
  task automatic write_reg(logic idx, logic [ttpd_pkg::DATA_W-1:0] value);
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ttpd_pkg::CFG_ADDR_W'(int'(idx) << ttpd_pkg::REG_IDX_LSB);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  initial begin
    int unsigned                 roll;
    logic [ttpd_pkg::DATA_W-1:0] smp;
    logic [ttpd_pkg::DATA_W-1:0] mask_val;

    sb          = new();
    clk         = 1'b0;
    rst_n       = 1'b0;
    no_idle     = 0;
    items_sent  = 0;
    stamp_run   = $urandom();
    last_sample = '0;

    in_chan.valid     <= 1'b0;
    in_chan.func      <= ttpd_pkg::FUNC_RECORD;
    in_chan.sample    <= '0;
    in_chan.timestamp <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed trace at the reset mask (bit 18)
    measure();                            // empty trace
    record(32'h0000_0000, 32'hFFFF_FFFF); // extreme timestamp
    record(32'h0004_0000, 32'h0000_0500); // first rise
    measure();                            // only one rising edge
    record(32'h0000_0000, 32'h0000_0500); // fall, zero high time
    record(32'h0004_0000, 32'h0000_0500); // second rise at same stamp
    measure();                            // period sum is zero
    record(32'h0000_0000, 32'h0000_0400);
    record(32'hFFFF_FFFF, 32'h0000_0300); // all-ones sample
    measure();                            // 0x100 average, 50 percent
    record(32'h0000_0000, 32'h0000_0010);
    record(32'h0004_0000, 32'hFFFF_FFF0); // timer wrapped between rises
    measure();

    // change-only mode: repeats of the last stored sample are dropped
    write_reg(ttpd_pkg::REG_CHANGE_ONLY, 32'h1);
    record(32'h0004_0000, 32'h0000_1234); // same as last stored, skipped
    record(32'h1234_5678, 32'h0000_0000); // zero timestamp
    record(32'h1234_5678, 32'h0000_0100); // skipped again
    measure();

    // mask extremes over the same trace
    write_reg(ttpd_pkg::REG_EDGE_MASK, 32'h0000_0000);
    measure();                            // nothing observed
    write_reg(ttpd_pkg::REG_EDGE_MASK, 32'hFFFF_FFFF);
    measure();

    // random phases, each with its own register setting
    for (int phase = 0; items_sent < 1800; phase++) begin
      case (phase)
        0:       mask_val = 32'hFFFF_FFFF;
        1:       mask_val = 32'h0000_0000;
        2:       mask_val = 32'h0000_0001;
        3:       mask_val = 32'h8000_0000;
        4:       mask_val = ttpd_pkg::EDGE_MASK_RST;
        default: mask_val = $urandom_range(1) ? (32'h1 << $urandom_range(31)) : $urandom();
      endcase
      write_reg(ttpd_pkg::REG_EDGE_MASK, mask_val);
      write_reg(ttpd_pkg::REG_CHANGE_ONLY, (phase < 2) ? phase : $urandom_range(1));
      // long stretch with no idling on either side
      no_idle = (phase == 2 || phase == 3);

      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(99) < 28) begin
          // mostly samples that toggle the observed bits, some repeats
          roll = $urandom_range(99);
          if (roll < 25)      smp = last_sample;
          else if (roll < 35) smp = '0;
          else if (roll < 45) smp = '1;
          else                smp = $urandom();
          // timer counts down, now and then an unrelated value
          if ($urandom_range(9) == 0) stamp_run = $urandom();
          else stamp_run = stamp_run - $urandom_range(1, 4000);
          record(smp, stamp_run);
        end else begin
          measure();
        end
      end
    end

    // drain: everything owed, then the measure latency again
    no_idle = 0;
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (200) @(posedge clk);

    if (sb.err_count == 0) begin
      $display("tb_timestamped_trace_period_duty_core passed");
    end else begin
      $display("tb_timestamped_trace_period_duty_core failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #8000000;
    $display("tb_timestamped_trace_period_duty_core failed");
    $finish;
  end

endmodule
